FILE: hdl/sstq_pkg.sv
package sstq_pkg;

  localparam int QUEUE_DEPTH = 16;
  localparam int IDX_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
  localparam int ID_W = 8;
  localparam int TICK_W = 63;

  localparam logic ACT_SLEEP = 1'b0;
  localparam logic ACT_TICK = 1'b1;

  typedef enum logic [1:0] {
    STATUS_INSERTED = 2'd0,
    STATUS_FULL     = 2'd1,
    STATUS_WOKEN    = 2'd2,
    STATUS_NONE_DUE = 2'd3
  } status_t;

  typedef enum logic [3:0] {
    S_IDLE  = 4'b0001,
    S_INS   = 4'b0010,
    S_PLACE = 4'b0100,
    S_TICK  = 4'b1000
  } state_t;

  typedef struct packed {
    logic [ID_W-1:0]   id;
    logic [TICK_W-1:0] tick;
  } entry_t;

  function automatic logic [IDX_W-1:0] idx_inc(input logic [IDX_W-1:0] i);
    if (i == IDX_W'(QUEUE_DEPTH - 1)) begin
      return '0;
    end
    return i + IDX_W'(1);
  endfunction

  function automatic logic [IDX_W-1:0] idx_dec(input logic [IDX_W-1:0] i);
    if (i == '0) begin
      return IDX_W'(QUEUE_DEPTH - 1);
    end
    return i - IDX_W'(1);
  endfunction

endpackage

FILE: hdl/sorted_sleep_timer_queue.sv
// Sorted sleep queue of sstq_pkg::QUEUE_DEPTH entries held in a ring buffer in one
// synchronous memory, kept in ascending wake-tick order (equal ticks in arrival order).
// Command port: an item is taken when start is high and busy is low. Results appear
// on out_* for exactly one cycle, marked by out_valid; the receiver cannot stall them,
// and there is no back-pressure. A sleep item gives one result: a full-queue reject
// or an insert into an empty queue is issued in the cycle after the transfer; any
// other insert moves each stored entry with a later wake tick up one slot in S_INS
// (one memory read and one write per cycle), then writes the new entry.
// A tick item pops one due entry per cycle from the head of the ring until an entry
// is not due or the ring is empty; each woken result is issued once the next
// entry has been checked, so out_last is exact. busy is high after the transfer of an
// item that enters S_INS or S_TICK until its final result is on the outputs.
module sorted_sleep_timer_queue (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                start,
  output logic                                busy,
  input  logic                                in_action,
  input  logic [sstq_pkg::ID_W-1:0]           in_entry_id,
  input  logic [sstq_pkg::TICK_W-1:0]         in_tick_value,
  output logic                                out_valid,
  output logic [1:0]                          out_status,
  output logic [sstq_pkg::ID_W-1:0]           out_woken_id,
  output logic                                out_last
);

  sstq_pkg::entry_t mem [sstq_pkg::QUEUE_DEPTH];
  sstq_pkg::entry_t rd_data_r;

  sstq_pkg::state_t state_r, state_nxt;
  logic [sstq_pkg::IDX_W-1:0] head_r, head_nxt;
  logic [sstq_pkg::IDX_W-1:0] tail_r, tail_nxt;
  logic [sstq_pkg::IDX_W-1:0] idx_r, idx_nxt;
  logic [sstq_pkg::CNT_W-1:0] count_r, count_nxt;
  logic [sstq_pkg::CNT_W-1:0] rem_r, rem_nxt;
  logic [sstq_pkg::ID_W-1:0]  new_id_r, new_id_nxt;
  logic [sstq_pkg::TICK_W-1:0] new_tick_r, new_tick_nxt;
  logic [sstq_pkg::ID_W-1:0]  pend_id_r, pend_id_nxt;
  logic                       pend_v_r, pend_v_nxt;

  logic                       out_valid_r, out_valid_nxt;
  sstq_pkg::status_t          out_status_r, out_status_nxt;
  logic [sstq_pkg::ID_W-1:0]  out_id_r, out_id_nxt;
  logic                       out_last_r, out_last_nxt;

  logic                       wr_en;
  logic [sstq_pkg::IDX_W-1:0] wr_addr;
  sstq_pkg::entry_t           wr_data;
  logic [sstq_pkg::IDX_W-1:0] rd_addr;
  logic                       rd_due;

  assign busy         = (state_r != sstq_pkg::S_IDLE);
  assign out_valid    = out_valid_r;
  assign out_status   = out_status_r;
  assign out_woken_id = out_id_r;
  assign out_last     = out_last_r;

  assign rd_due = (count_r != '0) && (rd_data_r.tick <= new_tick_r);

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data_r <= mem[rd_addr];
  end

  always_comb begin
    state_nxt      = state_r;
    head_nxt       = head_r;
    tail_nxt       = tail_r;
    idx_nxt        = idx_r;
    count_nxt      = count_r;
    rem_nxt        = rem_r;
    new_id_nxt     = new_id_r;
    new_tick_nxt   = new_tick_r;
    pend_id_nxt    = pend_id_r;
    pend_v_nxt     = pend_v_r;
    out_valid_nxt  = 1'b0;
    out_status_nxt = sstq_pkg::STATUS_INSERTED;
    out_id_nxt     = '0;
    out_last_nxt   = 1'b1;
    wr_en          = 1'b0;
    wr_addr        = idx_r;
    wr_data        = '{id: new_id_r, tick: new_tick_r};
    rd_addr        = head_r;

    unique case (state_r)
      sstq_pkg::S_IDLE: begin
        if (start) begin
          new_id_nxt   = in_entry_id;
          new_tick_nxt = in_tick_value;
          if (in_action == sstq_pkg::ACT_TICK) begin
            rd_addr    = head_r;
            pend_v_nxt = 1'b0;
            state_nxt  = sstq_pkg::S_TICK;
          end else if (count_r == sstq_pkg::CNT_W'(sstq_pkg::QUEUE_DEPTH)) begin
            out_valid_nxt  = 1'b1;
            out_status_nxt = sstq_pkg::STATUS_FULL;
          end else if (count_r == '0) begin
            wr_en         = 1'b1;
            wr_addr       = tail_r;
            wr_data       = '{id: in_entry_id, tick: in_tick_value};
            tail_nxt      = sstq_pkg::idx_inc(tail_r);
            count_nxt     = count_r + sstq_pkg::CNT_W'(1);
            out_valid_nxt = 1'b1;
          end else begin
            rd_addr   = sstq_pkg::idx_dec(tail_r);
            idx_nxt   = sstq_pkg::idx_dec(tail_r);
            rem_nxt   = count_r;
            state_nxt = sstq_pkg::S_INS;
          end
        end
      end

      sstq_pkg::S_INS: begin
        wr_en   = 1'b1;
        wr_addr = sstq_pkg::idx_inc(idx_r);
        if (rd_data_r.tick > new_tick_r) begin
          wr_data = rd_data_r;
          if (rem_r == sstq_pkg::CNT_W'(1)) begin
            state_nxt = sstq_pkg::S_PLACE;
          end else begin
            rd_addr = sstq_pkg::idx_dec(idx_r);
            idx_nxt = sstq_pkg::idx_dec(idx_r);
            rem_nxt = rem_r - sstq_pkg::CNT_W'(1);
          end
        end else begin
          tail_nxt      = sstq_pkg::idx_inc(tail_r);
          count_nxt     = count_r + sstq_pkg::CNT_W'(1);
          out_valid_nxt = 1'b1;
          state_nxt     = sstq_pkg::S_IDLE;
        end
      end

      sstq_pkg::S_PLACE: begin
        wr_en         = 1'b1;
        wr_addr       = idx_r;
        tail_nxt      = sstq_pkg::idx_inc(tail_r);
        count_nxt     = count_r + sstq_pkg::CNT_W'(1);
        out_valid_nxt = 1'b1;
        state_nxt     = sstq_pkg::S_IDLE;
      end

      sstq_pkg::S_TICK: begin
        if (rd_due) begin
          pend_id_nxt    = rd_data_r.id;
          pend_v_nxt     = 1'b1;
          head_nxt       = sstq_pkg::idx_inc(head_r);
          count_nxt      = count_r - sstq_pkg::CNT_W'(1);
          rd_addr        = sstq_pkg::idx_inc(head_r);
          out_valid_nxt  = pend_v_r;
          out_status_nxt = sstq_pkg::STATUS_WOKEN;
          out_id_nxt     = pend_id_r;
          out_last_nxt   = 1'b0;
        end else begin
          out_valid_nxt = 1'b1;
          if (pend_v_r) begin
            out_status_nxt = sstq_pkg::STATUS_WOKEN;
            out_id_nxt     = pend_id_r;
          end else begin
            out_status_nxt = sstq_pkg::STATUS_NONE_DUE;
          end
          state_nxt = sstq_pkg::S_IDLE;
        end
      end

      default: begin
        state_nxt = sstq_pkg::S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= sstq_pkg::S_IDLE;
      head_r      <= '0;
      tail_r      <= '0;
      count_r     <= '0;
      pend_v_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      head_r      <= head_nxt;
      tail_r      <= tail_nxt;
      count_r     <= count_nxt;
      pend_v_r    <= pend_v_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    idx_r        <= idx_nxt;
    rem_r        <= rem_nxt;
    new_id_r     <= new_id_nxt;
    new_tick_r   <= new_tick_nxt;
    pend_id_r    <= pend_id_nxt;
    out_status_r <= out_status_nxt;
    out_id_r     <= out_id_nxt;
    out_last_r   <= out_last_nxt;
  end

endmodule
